// File: rtl/sfc_pkg.sv
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types, constants and the CRC16-CCITT-FALSE byte step for the
// framed packet checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfc_pkg;

  localparam int TAG_BYTES    = 16;
  localparam int HEADER_BYTES = 18;
  localparam int CRC_BYTES    = 2;
  localparam int MIN_FRAME    = HEADER_BYTES + TAG_BYTES + CRC_BYTES;

  localparam int COUNT_W = 17;
  localparam int SPAN_W  = 18;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // header byte offsets
  localparam logic [4:0] OFS_MAGIC0  = 5'd0;
  localparam logic [4:0] OFS_MAGIC1  = 5'd1;
  localparam logic [4:0] OFS_VERSION = 5'd2;
  localparam logic [4:0] OFS_TYPE    = 5'd3;
  localparam logic [4:0] OFS_LEN_LO  = 5'd4;
  localparam logic [4:0] OFS_LEN_HI  = 5'd5;
  localparam logic [4:0] OFS_SEQ     = 5'd6;
  localparam logic [4:0] OFS_TIME    = 5'd10;
  localparam logic [4:0] OFS_IDENT   = 5'd14;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIRE_VERSION = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_KIND   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD  = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_TAG     = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  // verdict codes
  localparam logic [2:0] VERDICT_OK          = 3'd0;
  localparam logic [2:0] VERDICT_BAD_LENGTH  = 3'd1;
  localparam logic [2:0] VERDICT_BAD_MAGIC   = 3'd2;
  localparam logic [2:0] VERDICT_BAD_VERSION = 3'd3;
  localparam logic [2:0] VERDICT_BAD_TYPE    = 3'd4;
  localparam logic [2:0] VERDICT_BAD_CRC     = 3'd5;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [7:0]  out_byte;
    logic [2:0]  verdict;
    logic [31:0] seq_number;
    logic [31:0] time_ms;
    logic [7:0]  controller_code;
    logic [7:0]  link_code;
    logic [7:0]  content_type;
    logic [7:0]  content_length;
  } out_item_t;

  typedef struct packed {
    logic [7:0] magic_first;
    logic [7:0] magic_second;
    logic [7:0] wire_version;
    logic [7:0] frame_kind;
    logic [7:0] max_payload;
  } cfg_regs_t;

  function automatic logic [15:0] crc16_step(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// File: rtl/sfc_frame.sv
// ----------------------------------------------------------------------------
// sfc_frame
// Per-frame state: byte count, CRC, header capture and checks. Forms the
// result for each accepted byte in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfc_frame import sfc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  in_item_t  item,
  input  cfg_regs_t cfg,
  output logic      res_valid,
  output out_item_t res
);

  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [15:0]        running_crc, running_crc_next;
  logic [15:0]        held_bytes, held_bytes_next;
  logic [15:0]        length_field, length_field_next;
  logic [31:0]        seq_reg, seq_reg_next;
  logic [31:0]        time_reg, time_reg_next;
  logic [31:0]        ident_regs, ident_regs_next;
  logic [2:0]         header_error_flags, header_error_flags_next;

  logic [7:0]        b;
  logic [4:0]        ofs;
  logic              in_header;
  logic [1:0]        seq_lane, time_lane, ident_lane;
  logic [7:0]        plen;
  logic [SPAN_W-1:0] idx_w, pay_end, tag_end, expect_total;
  logic [2:0]        verdict;

  always_comb begin
    b         = item.rx_byte;
    idx_w     = SPAN_W'(byte_count);
    in_header = idx_w < SPAN_W'(HEADER_BYTES);
    ofs       = byte_count[4:0];
    seq_lane  = 2'(ofs - OFS_SEQ);
    time_lane = 2'(ofs - OFS_TIME);
    ident_lane = 2'(ofs - OFS_IDENT);

    running_crc_next        = (idx_w >= SPAN_W'(2)) ? crc16_step(running_crc, held_bytes[7:0])
                                                    : running_crc;
    held_bytes_next         = {b, held_bytes[15:8]};
    length_field_next       = length_field;
    seq_reg_next            = seq_reg;
    time_reg_next           = time_reg;
    ident_regs_next         = ident_regs;
    header_error_flags_next = header_error_flags;

    if (in_header) begin
      if (ofs == OFS_MAGIC0 && b != cfg.magic_first)  header_error_flags_next[0] = 1'b1;
      if (ofs == OFS_MAGIC1 && b != cfg.magic_second) header_error_flags_next[0] = 1'b1;
      if (ofs == OFS_VERSION && b != cfg.wire_version) header_error_flags_next[1] = 1'b1;
      if (ofs == OFS_TYPE && b != cfg.frame_kind)     header_error_flags_next[2] = 1'b1;
      if (ofs == OFS_LEN_LO) length_field_next[7:0]  = b;
      if (ofs == OFS_LEN_HI) length_field_next[15:8] = b;
      if (ofs >= OFS_SEQ && ofs < OFS_TIME) seq_reg_next[seq_lane*8 +: 8] = b;
      if (ofs >= OFS_TIME && ofs < OFS_IDENT) time_reg_next[time_lane*8 +: 8] = b;
      if (ofs >= OFS_IDENT) ident_regs_next[ident_lane*8 +: 8] = b;
    end

    byte_count_next = (byte_count != COUNT_MAX) ? byte_count + 1'b1 : byte_count;

    plen         = ident_regs_next[31:24];
    pay_end      = SPAN_W'(HEADER_BYTES) + SPAN_W'(plen);
    tag_end      = pay_end + SPAN_W'(TAG_BYTES);
    expect_total = tag_end + SPAN_W'(CRC_BYTES);

    if (byte_count_next < COUNT_W'(MIN_FRAME))                verdict = VERDICT_BAD_LENGTH;
    else if (header_error_flags_next[0])                      verdict = VERDICT_BAD_MAGIC;
    else if (header_error_flags_next[1])                      verdict = VERDICT_BAD_VERSION;
    else if (header_error_flags_next[2])                      verdict = VERDICT_BAD_TYPE;
    else if (COUNT_W'(length_field_next) != byte_count_next)  verdict = VERDICT_BAD_LENGTH;
    else if (plen > cfg.max_payload)                          verdict = VERDICT_BAD_LENGTH;
    else if (expect_total != SPAN_W'(byte_count_next))        verdict = VERDICT_BAD_LENGTH;
    else if (held_bytes_next != running_crc_next)             verdict = VERDICT_BAD_CRC;
    else                                                      verdict = VERDICT_OK;

    res.item_kind       = KIND_PAYLOAD;
    res.out_byte        = b;
    res.verdict         = VERDICT_OK;
    res.seq_number      = seq_reg_next;
    res.time_ms         = time_reg_next;
    res.controller_code = ident_regs_next[7:0];
    res.link_code       = ident_regs_next[15:8];
    res.content_type    = ident_regs_next[23:16];
    res.content_length  = ident_regs_next[31:24];
    res_valid           = 1'b0;

    if (item.end_of_frame) begin
      res.item_kind = KIND_VERDICT;
      res.out_byte  = 8'h00;
      res.verdict   = verdict;
      res_valid     = 1'b1;
    end else if (idx_w >= SPAN_W'(HEADER_BYTES) && idx_w < pay_end) begin
      res_valid = 1'b1;
    end else if (idx_w >= pay_end && idx_w < tag_end) begin
      res.item_kind = KIND_TAG;
      res_valid     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && item.end_of_frame)) begin
      byte_count         <= '0;
      running_crc        <= CRC_INIT;
      held_bytes         <= '0;
      length_field       <= '0;
      seq_reg            <= '0;
      time_reg           <= '0;
      ident_regs         <= '0;
      header_error_flags <= '0;
    end else if (accept) begin
      byte_count         <= byte_count_next;
      running_crc        <= running_crc_next;
      held_bytes         <= held_bytes_next;
      length_field       <= length_field_next;
      seq_reg            <= seq_reg_next;
      time_reg           <= time_reg_next;
      ident_regs         <= ident_regs_next;
      header_error_flags <= header_error_flags_next;
    end
  end

endmodule

// File: rtl/secure_frame_checker.sv
// ----------------------------------------------------------------------------
// secure_frame_checker
// Streaming checker for CRC16-CCITT-FALSE protected framed packets.
// ----------------------------------------------------------------------------
// One frame byte is offered per transfer on the in channel, with end_of_frame
// set on the final byte. Payload and auth tag bytes come out on the out
// channel as they arrive; the final byte gives one verdict item instead.
// Header and CRC bytes give no output. Every output item carries the header
// fields captured so far.
// Throughput is one byte per cycle while out_ready is high: the CRC byte
// step, header capture and all frame checks sit between the accepted byte
// and the output register, which is valid in the cycle after a result.
// The output register holds a result until it is taken; a new byte is
// accepted in the same cycle as an output transfer, so in_ready drops only
// while a result waits and out_ready is low.
// Configuration writes (cfg_index 0..4) are always accepted, are meant to be
// made between frames, and indexes past the list are ignored.
// Reset clears all frame state, sets the expected header bytes to zero and
// max_payload to 255, and empties the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module secure_frame_checker import sfc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  cfg_regs_t cfg;
  logic      accept;
  logic      res_valid;
  out_item_t res;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_first  <= 8'h00;
      cfg.magic_second <= 8'h00;
      cfg.wire_version <= 8'h00;
      cfg.frame_kind   <= 8'h00;
      cfg.max_payload  <= 8'hFF;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAGIC_FIRST:  cfg.magic_first  <= cfg_data;
        REG_MAGIC_SECOND: cfg.magic_second <= cfg_data;
        REG_WIRE_VERSION: cfg.wire_version <= cfg_data;
        REG_FRAME_KIND:   cfg.frame_kind   <= cfg_data;
        REG_MAX_PAYLOAD:  cfg.max_payload  <= cfg_data;
        default: ;
      endcase
    end
  end

  sfc_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (in_data),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_data <= res;
    end
  end

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the secure frame checker. Frames are built with a
// correct CRC16-CCITT-FALSE and then flawed on purpose: bad magic, version,
// type, declared length, oversize payload, extra bytes, bad CRC and early end
// marks. A byte-level decoder model predicts every payload, tag and verdict
// transfer; a monitor compares each output transfer field by field, while
// both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import sfc_pkg::*;

  localparam longint RUN_LIMIT_NS = 20_000_000;
  localparam int FLAG_MAGIC = 0;
  localparam int FLAG_VERSION = 1;
  localparam int FLAG_TYPE = 2;

  typedef enum int {
    FLAW_NONE, FLAW_MAGIC0, FLAW_MAGIC1, FLAW_VERSION, FLAW_TYPE,
    FLAW_LENGTH, FLAW_OVERSIZE, FLAW_EXTRA, FLAW_CRC, FLAW_SHORT
  } flaw_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  // register mirror
  logic [7:0] cfg_magic0 = 8'h00;
  logic [7:0] cfg_magic1 = 8'h00;
  logic [7:0] cfg_version = 8'h00;
  logic [7:0] cfg_kind = 8'h00;
  logic [7:0] cfg_max = 8'hFF;

  // decoder model state
  logic [COUNT_W-1:0] fr_count = '0;
  logic [15:0]        fr_crc = CRC_INIT;
  logic [15:0]        fr_held = '0;
  logic [15:0]        fr_len = '0;
  logic [31:0]        fr_seq = '0;
  logic [31:0]        fr_time = '0;
  logic [31:0]        fr_ident = '0;
  logic [2:0]         fr_flags = '0;

  out_item_t  decoded_q[$];
  out_item_t  want;
  logic [7:0] frame_buf[$];
  int         error_count = 0;
  int         bytes_sent = 0;
  bit         no_idle = 1'b0;

  secure_frame_checker u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = c[15] ^ b[k];
      c = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic out_item_t make_item(input logic [1:0] kind, input logic [7:0] b,
                                          input logic [2:0] v);
    out_item_t r;
    r.item_kind = kind;
    r.out_byte = b;
    r.verdict = v;
    r.seq_number = fr_seq;
    r.time_ms = fr_time;
    r.controller_code = fr_ident[7:0];
    r.link_code = fr_ident[15:8];
    r.content_type = fr_ident[23:16];
    r.content_length = fr_ident[31:24];
    return r;
  endfunction

  // one accepted frame byte through the decoder model
  function automatic void decode_byte(input logic [7:0] b, input logic eof);
    int unsigned idx;
    int unsigned plen;
    int unsigned total;
    logic [2:0]  v;
    idx = fr_count;
    if (idx >= 2) begin
      fr_crc = crc_next(fr_crc, fr_held[7:0]);
    end
    fr_held = {b, fr_held[15:8]};
    if (idx == OFS_MAGIC0 && b != cfg_magic0) fr_flags[FLAG_MAGIC] = 1'b1;
    if (idx == OFS_MAGIC1 && b != cfg_magic1) fr_flags[FLAG_MAGIC] = 1'b1;
    if (idx == OFS_VERSION && b != cfg_version) fr_flags[FLAG_VERSION] = 1'b1;
    if (idx == OFS_TYPE && b != cfg_kind) fr_flags[FLAG_TYPE] = 1'b1;
    if (idx == OFS_LEN_LO) fr_len[7:0] = b;
    if (idx == OFS_LEN_HI) fr_len[15:8] = b;
    if (idx >= OFS_SEQ && idx < OFS_TIME) fr_seq[8*(idx-OFS_SEQ) +: 8] = b;
    if (idx >= OFS_TIME && idx < OFS_IDENT) fr_time[8*(idx-OFS_TIME) +: 8] = b;
    if (idx >= OFS_IDENT && idx < HEADER_BYTES) fr_ident[8*(idx-OFS_IDENT) +: 8] = b;
    if (fr_count != COUNT_MAX) begin
      fr_count++;
    end
    plen = fr_ident[31:24];
    if (!eof) begin
      if (idx >= HEADER_BYTES && idx < HEADER_BYTES + plen) begin
        decoded_q.push_back(make_item(KIND_PAYLOAD, b, VERDICT_OK));
      end else if (idx >= HEADER_BYTES && idx < HEADER_BYTES + plen + TAG_BYTES) begin
        decoded_q.push_back(make_item(KIND_TAG, b, VERDICT_OK));
      end
      return;
    end
    total = fr_count;
    if (total < MIN_FRAME) v = VERDICT_BAD_LENGTH;
    else if (fr_flags[FLAG_MAGIC]) v = VERDICT_BAD_MAGIC;
    else if (fr_flags[FLAG_VERSION]) v = VERDICT_BAD_VERSION;
    else if (fr_flags[FLAG_TYPE]) v = VERDICT_BAD_TYPE;
    else if (int'(fr_len) != total) v = VERDICT_BAD_LENGTH;
    else if (plen > cfg_max) v = VERDICT_BAD_LENGTH;
    else if (HEADER_BYTES + plen + TAG_BYTES + CRC_BYTES != total) v = VERDICT_BAD_LENGTH;
    else if (fr_held != fr_crc) v = VERDICT_BAD_CRC;
    else v = VERDICT_OK;
    decoded_q.push_back(make_item(KIND_VERDICT, 8'h00, v));
    fr_count = '0;
    fr_crc = CRC_INIT;
    fr_held = '0;
    fr_len = '0;
    fr_seq = '0;
    fr_time = '0;
    fr_ident = '0;
    fr_flags = '0;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_val,
                                      input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_val, act_val);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected output transfer, expected none actual %0h",
                 $time, out_data);
        error_count++;
      end else begin
        want = decoded_q.pop_front();
        check_field("item_kind", want.item_kind, out_data.item_kind);
        check_field("out_byte", want.out_byte, out_data.out_byte);
        check_field("verdict", want.verdict, out_data.verdict);
        check_field("seq_number", want.seq_number, out_data.seq_number);
        check_field("time_ms", want.time_ms, out_data.time_ms);
        check_field("controller_code", want.controller_code, out_data.controller_code);
        check_field("link_code", want.link_code, out_data.link_code);
        check_field("content_type", want.content_type, out_data.content_type);
        check_field("content_length", want.content_length, out_data.content_length);
      end
    end
  end

  // output side stall per transfer
  initial begin
    int unsigned stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eof);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {b, eof};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_byte(b, eof);
    bytes_sent++;
  endtask

  // end mark goes on the last byte of frame_buf only
  task automatic send_span(input int from_i, input int to_i);
    for (int i = from_i; i < to_i; i++) begin
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
    end
  endtask

  task automatic send_frame();
    send_span(0, frame_buf.size());
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MAGIC_FIRST:  cfg_magic0 = val;
      REG_MAGIC_SECOND: cfg_magic1 = val;
      REG_WIRE_VERSION: cfg_version = val;
      REG_FRAME_KIND:   cfg_kind = val;
      REG_MAX_PAYLOAD:  cfg_max = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] m0, input logic [7:0] m1,
                              input logic [7:0] ver, input logic [7:0] kind,
                              input logic [7:0] maxp);
    settle();
    write_reg(REG_MAGIC_FIRST, m0);
    write_reg(REG_MAGIC_SECOND, m1);
    write_reg(REG_WIRE_VERSION, ver);
    write_reg(REG_FRAME_KIND, kind);
    write_reg(REG_MAX_PAYLOAD, maxp);
    // unused index, must be ignored
    write_reg(CFG_IDX_W'($urandom_range(REG_MAX_PAYLOAD + 1, (1 << CFG_IDX_W) - 1)),
              8'($urandom));
  endtask

  task automatic cut_frame(input int n);
    while (frame_buf.size() > n) void'(frame_buf.pop_back());
  endtask

  task automatic build_frame(input int plen, input flaw_t flaw);
    int          total;
    logic [7:0]  flip;
    logic [15:0] len16;
    logic [15:0] crc;
    flip = 8'h01 << $urandom_range(0, 7);
    if (flaw == FLAW_OVERSIZE && cfg_max != 8'hFF) begin
      plen = int'(cfg_max) + 1 + $urandom_range(0, 3);
      if (plen > 255) plen = 255;
    end else if (plen > cfg_max) begin
      plen = cfg_max;
    end
    total = MIN_FRAME + plen + ((flaw == FLAW_EXTRA) ? 1 : 0);
    len16 = total[15:0];
    if (flaw == FLAW_LENGTH) len16 = len16 ^ (16'h0001 << $urandom_range(0, 15));
    frame_buf = {};
    frame_buf.push_back(cfg_magic0 ^ ((flaw == FLAW_MAGIC0) ? flip : 8'h00));
    frame_buf.push_back(cfg_magic1 ^ ((flaw == FLAW_MAGIC1) ? flip : 8'h00));
    frame_buf.push_back(cfg_version ^ ((flaw == FLAW_VERSION) ? flip : 8'h00));
    frame_buf.push_back(cfg_kind ^ ((flaw == FLAW_TYPE) ? flip : 8'h00));
    frame_buf.push_back(len16[7:0]);
    frame_buf.push_back(len16[15:8]);
    repeat (11) frame_buf.push_back(8'($urandom));
    frame_buf.push_back(8'(plen));
    repeat (plen + TAG_BYTES) frame_buf.push_back(8'($urandom));
    if (flaw == FLAW_EXTRA) frame_buf.push_back(8'($urandom));
    crc = CRC_INIT;
    foreach (frame_buf[i]) crc = crc_next(crc, frame_buf[i]);
    if (flaw == FLAW_CRC) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    frame_buf.push_back(crc[7:0]);
    frame_buf.push_back(crc[15:8]);
    if (flaw == FLAW_SHORT) cut_frame($urandom_range(1, frame_buf.size() - 1));
  endtask

  task automatic test_reset_defaults();
    build_frame(0, FLAW_NONE);
    send_frame();
    build_frame(255, FLAW_NONE);
    send_frame();
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_header_checks();
    program_regs(8'hA5, 8'h5A, 8'h01, 8'h07, 8'd32);
    build_frame(2, FLAW_MAGIC0);
    send_frame();
    build_frame(1, FLAW_MAGIC1);
    send_frame();
    build_frame(3, FLAW_VERSION);
    send_frame();
    build_frame(0, FLAW_TYPE);
    send_frame();
    // short frame wins over a bad magic
    build_frame(4, FLAW_MAGIC0);
    cut_frame(10);
    send_frame();
  endtask

  task automatic test_length_checks();
    build_frame(3, FLAW_LENGTH);
    send_frame();
    build_frame(0, FLAW_OVERSIZE);
    send_frame();
    build_frame(2, FLAW_EXTRA);
    send_frame();
    build_frame(32, FLAW_NONE);
    send_frame();
  endtask

  task automatic test_crc_check();
    build_frame(5, FLAW_CRC);
    send_frame();
    build_frame(7, FLAW_NONE);
    send_frame();
  endtask

  task automatic test_partial_frames();
    build_frame(6, FLAW_NONE);
    cut_frame(HEADER_BYTES + 3);
    send_frame();
    build_frame(6, FLAW_NONE);
    cut_frame(HEADER_BYTES + 6 + 5);
    send_frame();
    build_frame(0, FLAW_NONE);
    cut_frame(MIN_FRAME - 1);
    send_frame();
    build_frame(4, FLAW_NONE);
    cut_frame(frame_buf.size() - 1);
    send_frame();
  endtask

  task automatic test_midframe_config();
    // header bytes are judged on arrival
    build_frame(5, FLAW_NONE);
    send_span(0, OFS_TYPE + 1);
    settle();
    write_reg(REG_MAGIC_FIRST, ~cfg_magic0);
    write_reg(REG_WIRE_VERSION, ~cfg_version);
    write_reg(REG_FRAME_KIND, ~cfg_kind);
    send_span(OFS_TYPE + 1, frame_buf.size());
    // payload limit is judged at the end mark
    build_frame(5, FLAW_NONE);
    send_span(0, HEADER_BYTES + 2);
    settle();
    write_reg(REG_MAX_PAYLOAD, 8'd4);
    send_span(HEADER_BYTES + 2, frame_buf.size());
    settle();
    write_reg(REG_MAX_PAYLOAD, 8'd32);
  endtask

  task automatic test_random_traffic();
    int    phase_end;
    int    plen;
    int    n;
    flaw_t flaw;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom));
        1: program_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00);
        2: program_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF);
        default: program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                              8'($urandom_range(8, 40)));
      endcase
      phase_end = bytes_sent + 115;
      while (bytes_sent < phase_end) begin
        no_idle = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0) begin
          // line noise
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) begin
            send_byte(8'($urandom), (i == n - 1) || ($urandom_range(0, 3) == 0));
          end
        end else begin
          flaw = ($urandom_range(0, 9) < 5) ? FLAW_NONE
                                            : flaw_t'($urandom_range(FLAW_MAGIC0, FLAW_SHORT));
          plen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
          build_frame(plen, flaw);
          send_frame();
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_header_checks();
    test_length_checks();
    test_crc_check();
    test_partial_frames();
    test_midframe_config();
    test_random_traffic();
    settle();
    repeat (8) @(posedge clk);
    if (error_count == 0 && decoded_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("tb_top failed");
    $finish;
  end

endmodule
